@@ hw/rtl/address_wait_table_unit_assert.svh @@
// Assertion macros for the address wait table unit.
`ifndef ADDRESS_WAIT_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_WAIT_TABLE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define AWT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define AWT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/awt_pkg.sv @@
`timescale 1ns / 1ps
package awt_pkg;

   localparam int KIND_W     = 2;
   localparam int THREAD_W   = 8;
   localparam int WAIT_ADDR_W = 32;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_SLEEP    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WAKE_ALL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WAKE_ONE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic [THREAD_W-1:0] woken_thread;
      logic                woken_valid;
      logic                has_sleepers;
      logic                status;
      logic                last;
   } rsp_word_type;

endpackage

@@ hw/rtl/awt_req_if.sv @@
`timescale 1ns / 1ps
interface awt_req_if import awt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [THREAD_W-1:0]    thread_id;
   logic [WAIT_ADDR_W-1:0] wait_addr;

   modport source (output valid, kind, thread_id, wait_addr, input ready);
   modport sink (input valid, kind, thread_id, wait_addr, output ready);
endinterface

@@ hw/rtl/awt_rsp_if.sv @@
`timescale 1ns / 1ps
interface awt_rsp_if import awt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [THREAD_W-1:0] woken_thread;
   logic                woken_valid;
   logic                has_sleepers;
   logic                status;
   logic                last;

   modport source (output valid, woken_thread, woken_valid, has_sleepers, status, last,
                   input ready);
   modport sink (input valid, woken_thread, woken_valid, has_sleepers, status, last,
                 output ready);
endinterface

@@ hw/rtl/awt_ram.sv @@
`timescale 1ns / 1ps
module awt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read that holds while not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/address_wait_table_unit.sv @@
`timescale 1ns / 1ps
// channel  | role   | beat fields
// ---------+--------+---------------------------------------------------------
// req_if   | sink   | kind, thread_id, wait_addr
// rsp_if   | source | woken_thread, woken_valid, has_sleepers, status, last
//
// A sleep appends the entry on acceptance and hands over the result from ST_DONE.
// A wake or query scans the entry RAM at one read per cycle while not stalled,
// processes the last entry, closes the pass, then sends one final beat.
// Survivors are compacted in place through the single write port during the pass.
// Reset clears the state, entry count and valid flags; the entry RAM needs no clearing pass.
// A full result register stalls each match after the first, and the final beat.
`include "address_wait_table_unit_assert.svh"
module address_wait_table_unit import awt_pkg::*; #(
   parameter int DEPTH      = 32,
   parameter int ADDR_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   awt_req_if.sink   req_if,
   awt_rsp_if.source rsp_if
);

   localparam int KEY_W = (ADDR_WIDTH < WAIT_ADDR_W) ? ADDR_WIDTH : WAIT_ADDR_W;
   localparam int RAM_W = THREAD_W + KEY_W;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   state_type           state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic                dv_ff, dv_in;
   logic                found_ff, found_in;
   logic                full_ff, full_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [THREAD_W-1:0] pend_thread_ff, pend_thread_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_ff, rsp_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [RAM_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [IDX_W-1:0]    ram_raddr;
   logic [RAM_W-1:0]    ram_rdata;

   logic                req_fire;
   logic                out_free;
   logic                is_wake;
   logic                hit;
   logic                take;
   logic                stall;
   logic [KEY_W-1:0]    entry_key;
   logic [THREAD_W-1:0] entry_thread;

   awt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign entry_key    = ram_rdata[KEY_W-1:0];
   assign entry_thread = ram_rdata[KEY_W +: THREAD_W];
   assign is_wake      = (kind_ff == KIND_WAKE_ALL) || (kind_ff == KIND_WAKE_ONE);
   assign hit          = dv_ff && (entry_key == key_ff);
   assign take         = hit && is_wake && ((kind_ff == KIND_WAKE_ALL) || !found_ff);
   assign stall        = take && pend_valid_ff && !out_free;

   // Sequencer: append, scan (with in-place compaction on a wake), final beat
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      dv_in          = dv_ff;
      found_in       = found_ff;
      full_in        = full_ff;
      pend_valid_in  = pend_valid_ff;
      pend_thread_in = pend_thread_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_in         = rsp_ff;
      ram_we         = 1'b0;
      ram_waddr      = wr_ptr_ff[IDX_W-1:0];
      ram_wdata      = ram_rdata;
      ram_re         = 1'b0;
      ram_raddr      = rd_ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in = req_if.kind;
               key_in  = req_if.wait_addr[KEY_W-1:0];
               if (req_if.kind == KIND_SLEEP) begin
                  // Append at the tail, or refuse when full
                  if (count_ff == DEPTH_CNT) begin
                     full_in = 1'b1;
                  end else begin
                     full_in   = 1'b0;
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[IDX_W-1:0];
                     ram_wdata = {req_if.thread_id, req_if.wait_addr[KEY_W-1:0]};
                     count_in  = count_ff + 1'b1;
                  end
                  state_in = ST_DONE;
               end else begin
                  rd_ptr_in     = '0;
                  wr_ptr_in     = '0;
                  dv_in         = 1'b0;
                  found_in      = 1'b0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               // Process the entry held in the RAM read register
               if (dv_ff) begin
                  if (take) begin
                     found_in       = 1'b1;
                     pend_valid_in  = 1'b1;
                     pend_thread_in = entry_thread;
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{woken_thread: pend_thread_ff, woken_valid: 1'b1,
                                         has_sleepers: 1'b0, status: 1'b0, last: 1'b0};
                     end
                  end else if (is_wake) begin
                     ram_we    = 1'b1;
                     ram_wdata = ram_rdata;
                     wr_ptr_in = wr_ptr_ff + 1'b1;
                  end
                  if (hit && !is_wake) begin
                     found_in = 1'b1;
                  end
               end
               // Issue the next read
               if (rd_ptr_ff != count_ff) begin
                  ram_re    = 1'b1;
                  rd_ptr_in = rd_ptr_ff + 1'b1;
                  dv_in     = 1'b1;
               end else begin
                  dv_in = 1'b0;
               end
               // Pass complete
               if (!dv_ff && (rd_ptr_ff == count_ff)) begin
                  if (is_wake) begin
                     count_in = wr_ptr_ff;
                  end
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{woken_thread: '0, woken_valid: 1'b0, has_sleepers: 1'b0,
                                status: 1'b0, last: 1'b1};
               if (kind_ff == KIND_SLEEP) begin
                  rsp_in.status = full_ff;
               end else if (kind_ff == KIND_QUERY) begin
                  rsp_in.has_sleepers = found_ff;
               end else if (pend_valid_ff) begin
                  rsp_in.woken_thread = pend_thread_ff;
                  rsp_in.woken_valid  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dv_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dv_ff         <= dv_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and scan registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      rd_ptr_ff      <= rd_ptr_in;
      wr_ptr_ff      <= wr_ptr_in;
      found_ff       <= found_in;
      full_ff        <= full_in;
      pend_thread_ff <= pend_thread_in;
      rsp_ff         <= rsp_in;
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.woken_thread = rsp_ff.woken_thread;
   assign rsp_if.woken_valid  = rsp_ff.woken_valid;
   assign rsp_if.has_sleepers = rsp_ff.has_sleepers;
   assign rsp_if.status       = rsp_ff.status;
   assign rsp_if.last         = rsp_ff.last;

   `AWT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= DEPTH_CNT, "entry count above depth")
   `AWT_ASSERT_NOW(a_compact_order, state_ff == ST_SCAN, wr_ptr_ff <= rd_ptr_ff, "write passed read")
   `AWT_ASSERT_NEXT(a_accept_busy, req_fire, state_ff != ST_IDLE, "accepted beat left block idle")
   `AWT_ASSERT_NEXT(a_query_keeps, (state_ff == ST_SCAN) && (kind_ff == KIND_QUERY), count_ff == $past(count_ff), "query changed count")
   `AWT_ASSERT_NOW(a_wake_fields, rsp_valid_ff && rsp_ff.woken_valid, !rsp_ff.has_sleepers && !rsp_ff.status, "wake beat mixed fields")

endmodule
